[sv/abbt_pkg.sv]
// ----------------------------------------------------------------------------
// abbt_pkg
// Shared types and constants of the transformed bounding box block.
// ----------------------------------------------------------------------------
package abbt_pkg;

    // opcode field values
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_BOX  = 1'b1;

    // matrix shape: three rows of {a, b, c, t}
    localparam int ROWS     = 3;
    localparam int COLS     = 4;
    localparam int COL_T    = 3;
    localparam int AXES     = 3;

    // queue between front and back
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    // words carried per queue entry (six box coordinates, or four coefficients)
    localparam int QWORDS   = 6;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_BOX  = 1'b1
    } t_kind;

    // head of the queue, as seen by the back part
    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [1:0] row;
    } t_q_head;

endpackage

[sv/abbt_if.sv]
// ----------------------------------------------------------------------------
// abbt_in_if / abbt_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface abbt_in_if #(parameter int CW = 32);
    logic                 valid;
    logic                 ready;
    logic                 opcode;
    logic [1:0]           row_index;
    logic signed [CW-1:0] coef_a;
    logic signed [CW-1:0] coef_b;
    logic signed [CW-1:0] coef_c;
    logic signed [CW-1:0] coef_t;
    logic signed [CW-1:0] box_min_x;
    logic signed [CW-1:0] box_min_y;
    logic signed [CW-1:0] box_min_z;
    logic signed [CW-1:0] box_max_x;
    logic signed [CW-1:0] box_max_y;
    logic signed [CW-1:0] box_max_z;

    modport source (output valid, opcode, row_index, coef_a, coef_b, coef_c, coef_t,
                    box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                    input ready);
    modport sink   (input valid, opcode, row_index, coef_a, coef_b, coef_c, coef_t,
                    box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                    output ready);
endinterface

interface abbt_out_if #(parameter int CW = 32);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] world_min_x;
    logic signed [CW-1:0] world_min_y;
    logic signed [CW-1:0] world_min_z;
    logic signed [CW-1:0] world_max_x;
    logic signed [CW-1:0] world_max_y;
    logic signed [CW-1:0] world_max_z;
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic signed [CW-1:0] center_z;
    logic signed [CW-1:0] extent_x;
    logic signed [CW-1:0] extent_y;
    logic signed [CW-1:0] extent_z;

    modport source (output valid, world_min_x, world_min_y, world_min_z,
                    world_max_x, world_max_y, world_max_z, center_x, center_y, center_z,
                    extent_x, extent_y, extent_z, input ready);
    modport sink   (input valid, world_min_x, world_min_y, world_min_z,
                    world_max_x, world_max_y, world_max_z, center_x, center_y, center_z,
                    extent_x, extent_y, extent_z, output ready);
endinterface

[sv/affine_box_bounds_transform_core.sv]
// ----------------------------------------------------------------------------
// affine_box_bounds_transform_core
// World-space bounds of a local axis-aligned box under a 3x4 affine matrix.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries two kinds of transaction. opcode load writes one matrix
//   row {a, b, c, t} at row_index (x, y, z; row three is ignored) and gives
//   no result. opcode box carries min and max corners and gives one result
//   on o_out: world min, max, center and extent, all signed fixed point,
//   saturated.
//   Throughput: one transaction per cycle unless o_out stalls, set by the
//   fully pipelined back end (18 multipliers working in parallel on every
//   box). A box accepted on i_in passes the queue, products, bound select,
//   sum and clamp, and center and extent registers before it shows on o_out.
//   Loads and boxes keep their order through the two-entry queue, so a box
//   always sees every row loaded ahead of it.
//   Reset (i_rst_n low, synchronous) zeroes the matrix, empties the queue
//   and drops every result in flight.
//   When o_out stalls, the whole back pipeline holds; the front keeps
//   taking transactions until the queue fills, then drops i_in.ready.
// ----------------------------------------------------------------------------
module affine_box_bounds_transform_core
    import abbt_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    abbt_in_if.sink     i_in,
    abbt_out_if.source  o_out
);

    t_q_head                       w_head;
    logic [QWORDS*COORD_WIDTH-1:0] w_data;
    logic                          w_pop;

    // front: accept, classify, queue
    abbt_front #(.CW(COORD_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_data  (w_data)
    );

    // back: matrix store and bound pipeline
    abbt_back #(.CW(COORD_WIDTH), .FB(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_data  (w_data),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

[sv/abbt_front.sv]
// ----------------------------------------------------------------------------
// abbt_front
// Accept items, drop loads to the unused row, queue the rest for the back part.
// ----------------------------------------------------------------------------
module abbt_front
    import abbt_pkg::*;
#(
    parameter int CW = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    abbt_in_if.sink                i_in,
    input  logic                   i_pop,
    output t_q_head                o_head,
    output logic [QWORDS*CW-1:0]   o_data
);

    localparam int EW = 1 + 2 + QWORDS*CW;

    logic [EW-1:0]      r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wptr, r_rptr;
    logic [QCNT_W-1:0]  r_cnt;
    logic [EW-1:0]      n_entry;
    logic               w_acc, w_push;

    assign i_in.ready = (r_cnt != QCNT_W'(QDEPTH));
    assign w_acc      = i_in.valid && i_in.ready;
    // a load aimed past the last row has no effect: drop it here
    assign w_push     = w_acc && !(i_in.opcode == OP_LOAD && i_in.row_index == 2'd3);

    always_comb begin
        if (i_in.opcode == OP_LOAD) begin
            n_entry = {KIND_LOAD, i_in.row_index,
                       {(2*CW){1'b0}},
                       i_in.coef_t, i_in.coef_c, i_in.coef_b, i_in.coef_a};
        end else begin
            n_entry = {KIND_BOX, 2'd0,
                       i_in.box_max_z, i_in.box_max_y, i_in.box_max_x,
                       i_in.box_min_z, i_in.box_min_y, i_in.box_min_x};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QDEPTH-1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QDEPTH-1)) ? '0 : r_rptr + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(w_push) - QCNT_W'(i_pop);
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.kind  = t_kind'(r_mem[r_rptr][EW-1]);
    assign o_head.row   = r_mem[r_rptr][EW-2:EW-3];
    assign o_data       = r_mem[r_rptr][QWORDS*CW-1:0];

endmodule

[sv/abbt_back.sv]
// ----------------------------------------------------------------------------
// abbt_back
// Hold the matrix, run the corner bound pipeline, drive the result register.
// ----------------------------------------------------------------------------
module abbt_back
    import abbt_pkg::*;
#(
    parameter int CW = 32,
    parameter int FB = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_q_head                i_head,
    input  logic [QWORDS*CW-1:0]   i_data,
    output logic                   o_pop,
    abbt_out_if.source             o_out
);

    localparam int PW = 2*CW;      // exact product
    localparam int AW = 2*CW + 2;  // three products plus translation

    logic signed [CW-1:0] r_mat [ROWS][COLS];

    logic                 w_en;
    logic                 r_v1, r_v2, r_v3, r_ov;
    logic signed [PW-1:0] r_p   [AXES][3][2];
    logic signed [CW-1:0] r_t1  [AXES];
    logic signed [PW-1:0] r_lo2 [AXES][3];
    logic signed [PW-1:0] r_hi2 [AXES][3];
    logic signed [CW-1:0] r_t2  [AXES];
    logic signed [CW-1:0] r_wmin[AXES];
    logic signed [CW-1:0] r_wmax[AXES];
    logic signed [CW-1:0] r_omin[AXES], r_omax[AXES], r_octr[AXES], r_oext[AXES];

    logic signed [CW-1:0] w_lo [3];
    logic signed [CW-1:0] w_hi [3];
    logic signed [AW-1:0] n_slo[AXES], n_shi[AXES];
    logic signed [CW-1:0] n_wmin[AXES], n_wmax[AXES];
    logic signed [CW:0]   n_sum[AXES], n_dif[AXES];

    function automatic logic signed [CW-1:0] sat_shift(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] s;
        logic                 fits;
        s    = v >>> FB;
        fits = (s[AW-1:CW-1] == '0) || (s[AW-1:CW-1] == '1);
        if (fits) begin
            sat_shift = s[CW-1:0];
        end else if (v[AW-1]) begin
            sat_shift = {1'b1, {(CW-1){1'b0}}};
        end else begin
            sat_shift = {1'b0, {(CW-1){1'b1}}};
        end
    endfunction

    // stall everything together only when the result register is held
    assign w_en  = !r_ov || o_out.ready;
    assign o_pop = w_en && i_head.valid;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_lo[j] = i_data[j*CW +: CW];
            w_hi[j] = i_data[(j+3)*CW +: CW];
        end
    end

    // matrix rows land in queue order, so each box sees the loads ahead of it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                for (int c = 0; c < COLS; c++) begin
                    r_mat[r][c] <= '0;
                end
            end
        end else if (o_pop && i_head.kind == KIND_LOAD) begin
            for (int c = 0; c < COLS; c++) begin
                r_mat[i_head.row][c] <= i_data[c*CW +: CW];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_v1 <= o_pop && i_head.kind == KIND_BOX;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_ov <= r_v3;
        end
    end

    // the bound of a sum of per-axis terms is the sum of per-term bounds,
    // and the shift and clamp afterwards are monotonic
    always_comb begin
        for (int ax = 0; ax < AXES; ax++) begin
            n_slo[ax] = (AW'(r_t2[ax]) <<< FB);
            n_shi[ax] = (AW'(r_t2[ax]) <<< FB);
            for (int j = 0; j < 3; j++) begin
                n_slo[ax] = n_slo[ax] + AW'(r_lo2[ax][j]);
                n_shi[ax] = n_shi[ax] + AW'(r_hi2[ax][j]);
            end
            n_wmin[ax] = sat_shift(n_slo[ax]);
            n_wmax[ax] = sat_shift(n_shi[ax]);
            n_sum[ax]  = (CW+1)'(r_wmin[ax]) + (CW+1)'(r_wmax[ax]);
            n_dif[ax]  = (CW+1)'(r_wmax[ax]) - (CW+1)'(r_wmin[ax]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int ax = 0; ax < AXES; ax++) begin
                for (int j = 0; j < 3; j++) begin
                    r_p[ax][j][0] <= r_mat[ax][j] * w_lo[j];
                    r_p[ax][j][1] <= r_mat[ax][j] * w_hi[j];
                    r_lo2[ax][j]  <= (r_p[ax][j][0] < r_p[ax][j][1]) ?
                                     r_p[ax][j][0] : r_p[ax][j][1];
                    r_hi2[ax][j]  <= (r_p[ax][j][0] < r_p[ax][j][1]) ?
                                     r_p[ax][j][1] : r_p[ax][j][0];
                end
                r_t1[ax]   <= r_mat[ax][COL_T];
                r_t2[ax]   <= r_t1[ax];
                r_wmin[ax] <= n_wmin[ax];
                r_wmax[ax] <= n_wmax[ax];
                r_omin[ax] <= r_wmin[ax];
                r_omax[ax] <= r_wmax[ax];
                r_octr[ax] <= n_sum[ax][CW:1];
                r_oext[ax] <= (n_dif[ax][CW:CW-1] != 2'b00) ?
                              {1'b0, {(CW-1){1'b1}}} : n_dif[ax][CW-1:0];
            end
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.world_min_x = r_omin[0];
    assign o_out.world_min_y = r_omin[1];
    assign o_out.world_min_z = r_omin[2];
    assign o_out.world_max_x = r_omax[0];
    assign o_out.world_max_y = r_omax[1];
    assign o_out.world_max_z = r_omax[2];
    assign o_out.center_x    = r_octr[0];
    assign o_out.center_y    = r_octr[1];
    assign o_out.center_z    = r_octr[2];
    assign o_out.extent_x    = r_oext[0];
    assign o_out.extent_y    = r_oext[1];
    assign o_out.extent_z    = r_oext[2];

endmodule

[sv/abbt_checker.sv]
// ----------------------------------------------------------------------------
// abbt_checker
// Port-level checks of the transformed bounding box block.
// ----------------------------------------------------------------------------
module abbt_checker #(
    parameter int CW = 32
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input logic [CW-1:0] i_ext_x,
    input logic [CW-1:0] i_ext_y,
    input logic [CW-1:0] i_ext_z
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid && i_in_ready)
        else $error("block not empty after reset");

    a_ext_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_ext_x[CW-1] && !i_ext_y[CW-1] && !i_ext_z[CW-1])
        else $error("negative extent");

endmodule

bind affine_box_bounds_transform_core abbt_checker #(.CW(COORD_WIDTH)) u_abbt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_ext_x     (o_out.extent_x),
    .i_ext_y     (o_out.extent_y),
    .i_ext_z     (o_out.extent_z)
);
